/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file qbcl_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/qbcl_pkg.sv */
// ----------------------------------------------------------------------------
// qbcl_pkg
// Shared constants and types of the quadtree box cell locator.
// ----------------------------------------------------------------------------
`default_nettype none

package qbcl_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_LEVELS = 16;

	localparam int IN_W     = COORD_BITS + 1;
	localparam int SIZE_W   = 5;
	localparam int LVL_W    = $clog2(MAX_LEVELS + 1);
	localparam int MORTON_W = 2 * MAX_LEVELS;
	localparam int SHAMT_W  = LVL_W + 1;
	localparam int LANE_W   = (COORD_BITS > MAX_LEVELS) ? COORD_BITS : MAX_LEVELS;
	localparam int CODE_W   = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	typedef enum logic [1:0] {
		REG_ORIGIN_X   = 2'd0,
		REG_ORIGIN_Y   = 2'd1,
		REG_SIZE_BITS  = 2'd2,
		REG_TREE_DEPTH = 2'd3
	} reg_idx_t;

	// Settings seen by the datapath, already saturated.
	typedef struct packed {
		logic [COORD_BITS-1:0] origin_x;
		logic [COORD_BITS-1:0] origin_y;
		logic [COORD_BITS-1:0] span;
		logic [LVL_W-1:0]      depth;
		logic [SIZE_W-1:0]     shift;
	} cfg_t;

endpackage

`default_nettype wire

/* sv/qbcl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// qbcl_cfg_regs
// APB register file; derives effective size, depth and shift for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module qbcl_cfg_regs import qbcl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [COORD_BITS-1:0] origin_x_q;
	logic [COORD_BITS-1:0] origin_y_q;
	logic [SIZE_W-1:0]     size_bits_q;
	logic [SIZE_W-1:0]     tree_depth_q;
	reg_idx_t              idx;
	logic                  wr_en;
	logic [SIZE_W-1:0]     sz_eff;
	logic [SIZE_W-1:0]     d_eff;
	logic [COORD_BITS:0]   pow;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			size_bits_q  <= SIZE_W'(16);
			tree_depth_q <= SIZE_W'(4);
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN_X:   origin_x_q   <= pwdata[COORD_BITS-1:0];
				REG_ORIGIN_Y:   origin_y_q   <= pwdata[COORD_BITS-1:0];
				REG_SIZE_BITS:  size_bits_q  <= pwdata[SIZE_W-1:0];
				REG_TREE_DEPTH: tree_depth_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN_X:   prdata = DATA_W'(origin_x_q);
			REG_ORIGIN_Y:   prdata = DATA_W'(origin_y_q);
			REG_SIZE_BITS:  prdata = DATA_W'(size_bits_q);
			REG_TREE_DEPTH: prdata = DATA_W'(tree_depth_q);
			default:        prdata = '0;
		endcase
	end

	// Saturate size to the coordinate width, depth to size and level count.
	always_comb begin
		sz_eff = (size_bits_q > SIZE_W'(COORD_BITS)) ? SIZE_W'(COORD_BITS) : size_bits_q;
		d_eff  = tree_depth_q;
		if (d_eff > sz_eff)
			d_eff = sz_eff;
		if (d_eff > SIZE_W'(MAX_LEVELS))
			d_eff = SIZE_W'(MAX_LEVELS);
		pow          = (COORD_BITS + 1)'(1) << sz_eff;
		cfg.origin_x = origin_x_q;
		cfg.origin_y = origin_y_q;
		cfg.span     = COORD_BITS'(pow - (COORD_BITS + 1)'(1));
		cfg.depth    = LVL_W'(d_eff);
		cfg.shift    = sz_eff - d_eff;
	end

endmodule

`default_nettype wire

/* sv/qbcl_pipe.sv */
// ----------------------------------------------------------------------------
// qbcl_pipe
// Four-stage datapath: range check, Morton interleave, prefix search, extract.
// ----------------------------------------------------------------------------
`default_nettype none

module qbcl_pipe import qbcl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [IN_W-1:0]   left_x,
	input  wire logic [IN_W-1:0]   top_y,
	input  wire logic [IN_W-1:0]   right_x,
	input  wire logic [IN_W-1:0]   bottom_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   outside,
	output logic [LVL_W-1:0]       shared_levels,
	output logic [CODE_W-1:0]      cell_code
);

	function automatic logic in_region(input logic [IN_W-1:0] v,
	                                   input logic [COORD_BITS-1:0] org,
	                                   input logic [COORD_BITS-1:0] span);
		logic [IN_W-1:0] lo;
		logic [IN_W-1:0] hi;
		lo = IN_W'(org);
		hi = IN_W'(org) + IN_W'(span);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic [MORTON_W-1:0] interleave(input logic [LANE_W-1:0] x,
	                                                   input logic [LANE_W-1:0] y);
		logic [MORTON_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			m[2*i+1] = x[i];
			m[2*i]   = y[i];
		end
		return m;
	endfunction

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// Each stage advances when empty or when the next one advances.
	assign rdy4     = !v4_s4 || !out_stall;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	// Stage 1: region check and origin-relative coordinates.
	logic                  out_s1;
	logic [COORD_BITS-1:0] lx_s1, ty_s1, rx_s1, by_s1;
	logic [LVL_W-1:0]      depth_s1;
	logic [SIZE_W-1:0]     sh_s1;
	logic                  ok_c;

	assign ok_c = in_region(left_x,   cfg.origin_x, cfg.span) &&
	              in_region(top_y,    cfg.origin_y, cfg.span) &&
	              in_region(right_x,  cfg.origin_x, cfg.span) &&
	              in_region(bottom_y, cfg.origin_y, cfg.span);

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			out_s1   <= !ok_c;
			lx_s1    <= COORD_BITS'(left_x   - IN_W'(cfg.origin_x));
			ty_s1    <= COORD_BITS'(top_y    - IN_W'(cfg.origin_y));
			rx_s1    <= COORD_BITS'(right_x  - IN_W'(cfg.origin_x));
			by_s1    <= COORD_BITS'(bottom_y - IN_W'(cfg.origin_y));
			depth_s1 <= cfg.depth;
			sh_s1    <= cfg.shift;
		end
	end

	// Stage 2: drop to tree depth and interleave x above y.
	logic                out_s2;
	logic [MORTON_W-1:0] a_s2, b_s2;
	logic [LVL_W-1:0]    depth_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v1_s1) begin
			out_s2   <= out_s1;
			a_s2     <= interleave(LANE_W'(lx_s1) >> sh_s1, LANE_W'(ty_s1) >> sh_s1);
			b_s2     <= interleave(LANE_W'(rx_s1) >> sh_s1, LANE_W'(by_s1) >> sh_s1);
			depth_s2 <= depth_s1;
		end
	end

	// Stage 3: find the highest level where the corners part.
	logic                out_s3;
	logic [MORTON_W-1:0] a_s3;
	logic [LVL_W-1:0]    shared_s3;
	logic [SHAMT_W-1:0]  shamt_s3;
	logic [MORTON_W-1:0] diff_c;
	logic                found_c;
	logic [LVL_W-1:0]    grp_c;

	always_comb begin
		diff_c  = a_s2 ^ b_s2;
		found_c = 1'b0;
		grp_c   = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (diff_c[2*i+1] || diff_c[2*i]) begin
				found_c = 1'b1;
				grp_c   = LVL_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			out_s3    <= out_s2;
			a_s3      <= a_s2;
			shared_s3 <= found_c ? (depth_s2 - grp_c - LVL_W'(1)) : depth_s2;
			shamt_s3  <= found_c ? {grp_c + LVL_W'(1), 1'b0} : '0;
		end
	end

	// Stage 4: extract the shared prefix, zero everything for outside boxes.
	logic                out_s4;
	logic [LVL_W-1:0]    shared_s4;
	logic [CODE_W-1:0]   code_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v3_s3) begin
			out_s4    <= out_s3;
			shared_s4 <= out_s3 ? '0 : shared_s3;
			code_s4   <= out_s3 ? '0 : CODE_W'(a_s3 >> shamt_s3);
		end
	end

	assign out_valid     = v4_s4;
	assign outside       = out_s4;
	assign shared_levels = shared_s4;
	assign cell_code     = code_s4;

endmodule

`default_nettype wire

/* sv/quadtree_box_cell_locator.sv */
// ----------------------------------------------------------------------------
// quadtree_box_cell_locator
// Locates the deepest quadtree cell that holds a box, as level count and code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one box word: left_x, top_y,
//   right_x, bottom_y. A word is taken at a clock edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall) carries outside,
//   shared_levels and cell_code, one result word per box, in order.
//   Each box passes the four register stages in order: range check, Morton
//   interleave, prefix search and prefix extract; out_valid rises when its
//   result word reaches the last stage. One box per cycle is sustained while
//   out_stall stays low.
//   When the receiver holds out_stall, the output word holds and the stages
//   behind it fill up; in_stall rises once all four stages hold a word, so
//   nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the registers with origin 0,
//   size_bits 16, tree_depth 4. Write the APB registers only while the block
//   is empty; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module quadtree_box_cell_locator import qbcl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [IN_W-1:0]   left_x,
	input  wire logic [IN_W-1:0]   top_y,
	input  wire logic [IN_W-1:0]   right_x,
	input  wire logic [IN_W-1:0]   bottom_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   outside,
	output logic [LVL_W-1:0]       shared_levels,
	output logic [CODE_W-1:0]      cell_code
);

	cfg_t cfg;

	qbcl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qbcl_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_x        (left_x),
		.top_y         (top_y),
		.right_x       (right_x),
		.bottom_y      (bottom_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.outside       (outside),
		.shared_levels (shared_levels),
		.cell_code     (cell_code)
	);

endmodule

`default_nettype wire

/* sv/qbcl_checker.sv */
// ----------------------------------------------------------------------------
// qbcl_checker
// Port-level checks of the box cell locator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qbcl_checker import qbcl_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              outside,
	input wire logic [LVL_W-1:0]  shared_levels,
	input wire logic [CODE_W-1:0] cell_code
);

	// A stalled result word stays offered.
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid)

	// Boxes that leave the region carry no level or code.
	`ASSERT_IMPLY(a_outside_zero, clk, arst_n, out_valid && outside, (shared_levels == '0) && (cell_code == '0))

	// No shared level means an empty prefix.
	`ASSERT_IMPLY(a_no_level_no_code, clk, arst_n, out_valid && (shared_levels == '0), cell_code == '0)

	// Level count never exceeds the tree limit.
	`ASSERT_IMPLY(a_level_bound, clk, arst_n, out_valid, shared_levels <= LVL_W'(MAX_LEVELS))

endmodule

bind quadtree_box_cell_locator qbcl_checker u_qbcl_checker (.*);

`default_nettype wire

/* dv/cell_locator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_locator_checker
// Tracks the register settings from the APB port and predicts the result
// word of every box the locator takes. Compares each result word with the
// oldest prediction and counts the mismatches for the testbench top.
// ----------------------------------------------------------------------------
module cell_locator_checker import qbcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [IN_W-1:0]   left_x,
	input  logic [IN_W-1:0]   top_y,
	input  logic [IN_W-1:0]   right_x,
	input  logic [IN_W-1:0]   bottom_y,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              outside,
	input  logic [LVL_W-1:0]  shared_levels,
	input  logic [CODE_W-1:0] cell_code,
	output int                mismatches,
	output int                cells_pending
);

	typedef struct packed {
		logic              outside;
		logic [LVL_W-1:0]  levels;
		logic [CODE_W-1:0] code;
	} cell_word_t;

	logic [COORD_BITS-1:0] org_x;
	logic [COORD_BITS-1:0] org_y;
	logic [SIZE_W-1:0]     size_bits;
	logic [SIZE_W-1:0]     tree_depth;
	cell_word_t            cells_due[$];
	cell_word_t            due;

	function automatic bit covers(int unsigned v, int unsigned org, int unsigned esz);
		return v >= org && v <= org + (32'd1 << esz) - 1;
	endfunction

	function automatic logic [MORTON_W-1:0] interleave(logic [31:0] xs, logic [31:0] ys,
			int unsigned dep);
		logic [MORTON_W-1:0] key;
		key = '0;
		for (int i = 0; i < dep; i++) begin
			key[2*i+1] = xs[i];
			key[2*i]   = ys[i];
		end
		return key;
	endfunction

	function automatic cell_word_t locate_box(int unsigned lx, ty, rx, by);
		cell_word_t          w;
		int unsigned         esz, dep, sh, lvl;
		logic [MORTON_W-1:0] ka, kb;
		bit                  split;
		w = '0;
		esz = (size_bits > COORD_BITS) ? COORD_BITS : size_bits;
		dep = (tree_depth > esz) ? esz : tree_depth;
		if (dep > MAX_LEVELS)
			dep = MAX_LEVELS;
		sh = esz - dep;
		if (!(covers(lx, org_x, esz) && covers(ty, org_y, esz) &&
				covers(rx, org_x, esz) && covers(by, org_y, esz))) begin
			w.outside = 1'b1;
			return w;
		end
		ka = interleave((lx - org_x) >> sh, (ty - org_y) >> sh, dep);
		kb = interleave((rx - org_x) >> sh, (by - org_y) >> sh, dep);
		// walk from the coarsest level down until the quadrants differ
		lvl = 0;
		split = 1'b0;
		while (lvl < dep && !split) begin
			if (ka[2*(dep-1-lvl) +: 2] != kb[2*(dep-1-lvl) +: 2])
				split = 1'b1;
			else
				lvl++;
		end
		w.levels = LVL_W'(lvl);
		if (lvl > 0)
			w.code = CODE_W'(ka >> (2 * (dep - lvl)));
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x <= '0;
			org_y <= '0;
			size_bits <= 5'd16;
			tree_depth <= 5'd4;
			cells_due.delete();
			mismatches = 0;
			cells_pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_ORIGIN_X:   org_x <= pwdata[COORD_BITS-1:0];
					REG_ORIGIN_Y:   org_y <= pwdata[COORD_BITS-1:0];
					REG_SIZE_BITS:  size_bits <= pwdata[SIZE_W-1:0];
					REG_TREE_DEPTH: tree_depth <= pwdata[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				cells_due.push_back(locate_box(left_x, top_y, right_x, bottom_y));
			if (out_valid && !out_stall) begin
				if (cells_due.size() == 0) begin
					$display("%0t ns: result word with none expected: outside %0d levels %0d code %h",
						$time, outside, shared_levels, cell_code);
					mismatches++;
				end else begin
					due = cells_due.pop_front();
					if (outside !== due.outside) begin
						$display("%0t ns: outside expected %0d got %0d", $time, due.outside, outside);
						mismatches++;
					end
					if (shared_levels !== due.levels) begin
						$display("%0t ns: shared_levels expected %0d got %0d", $time, due.levels,
							shared_levels);
						mismatches++;
					end
					if (cell_code !== due.code) begin
						$display("%0t ns: cell_code expected %h got %h", $time, due.code, cell_code);
						mismatches++;
					end
				end
			end
			cells_pending = cells_due.size();
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Sends boxes into the quadtree box cell locator under a series of region
// settings, with random gaps and stalls on both channels and one long output
// hold-off. The checker beside the block predicts and compares each word.
// ----------------------------------------------------------------------------
module tb;
	import qbcl_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_BOXES  = 56;

	typedef struct packed {
		logic [IN_W-1:0] lx;
		logic [IN_W-1:0] ty;
		logic [IN_W-1:0] rx;
		logic [IN_W-1:0] by;
	} box_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [IN_W-1:0]   left_x = '0;
	logic [IN_W-1:0]   top_y = '0;
	logic [IN_W-1:0]   right_x = '0;
	logic [IN_W-1:0]   bottom_y = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              outside;
	logic [LVL_W-1:0]  shared_levels;
	logic [CODE_W-1:0] cell_code;
	int                mismatches;
	int                cells_pending;

	int          boxes_sent = 0;
	int          words_taken = 0;
	int          cycles = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          rx_holding = 1'b0;
	int unsigned cur_ox = 0;
	int unsigned cur_oy = 0;
	int unsigned cur_esz = 16;

	quadtree_box_cell_locator dut (.*);

	cell_locator_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic box_t mk_box(int unsigned lx, ty, rx, by);
		box_t b;
		b.lx = IN_W'(lx);
		b.ty = IN_W'(ty);
		b.rx = IN_W'(rx);
		b.by = IN_W'(by);
		return b;
	endfunction

	// random point near v, kept inside [lo, hi]
	function automatic int unsigned near(int unsigned v, int unsigned lo, int unsigned hi);
		int unsigned d;
		d = $urandom_range((1 << $urandom_range(cur_esz, 0)) - 1, 0);
		if ($urandom_range(1, 0))
			return (v + d > hi) ? hi : v + d;
		return (v - lo < d) ? lo : v - d;
	endfunction

	function automatic int unsigned just_out(int unsigned lo, int unsigned hi);
		return $urandom_range(1, 0) ? lo - 1 : hi + 1;
	endfunction

	function automatic box_t draw_box();
		box_t        b;
		int unsigned hx, hy, pick;
		hx = cur_ox + (1 << cur_esz) - 1;
		hy = cur_oy + (1 << cur_esz) - 1;
		pick = $urandom_range(99, 0);
		b = mk_box($urandom_range(hx, cur_ox), $urandom_range(hy, cur_oy),
			$urandom_range(hx, cur_ox), $urandom_range(hy, cur_oy));
		if (pick >= 85) begin
			b = mk_box($urandom, $urandom, $urandom, $urandom);
		end else if (pick >= 70) begin
			case ($urandom_range(3, 0))
				0: b.lx = IN_W'(just_out(cur_ox, hx));
				1: b.ty = IN_W'(just_out(cur_oy, hy));
				2: b.rx = IN_W'(just_out(cur_ox, hx));
				default: b.by = IN_W'(just_out(cur_oy, hy));
			endcase
		end else if (pick >= 35) begin
			// keep the corners close so that deep shared prefixes show up
			b.rx = IN_W'(near(b.lx, cur_ox, hx));
			b.by = IN_W'(near(b.ty, cur_oy, hy));
		end
		return b;
	endfunction

	task automatic send_box(input box_t b);
		int unsigned gap;
		gap = (tx_quiet || rx_holding) ? 0 : $urandom_range(12, 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_x <= b.lx;
		top_y <= b.ty;
		right_x <= b.rx;
		bottom_y <= b.by;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		boxes_sent++;
		if (boxes_sent % 40 == 0)
			tx_quiet = ($urandom_range(3, 0) == 0);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		while (words_taken != boxes_sent)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_corner_boxes();
		int unsigned hx, hy;
		hx = cur_ox + (1 << cur_esz) - 1;
		hy = cur_oy + (1 << cur_esz) - 1;
		send_box(mk_box(cur_ox, cur_oy, cur_ox, cur_oy));
		send_box(mk_box(hx, hy, hx, hy));
		send_box(mk_box(cur_ox, cur_oy, hx, hy));
		send_box(mk_box(hx, hy, cur_ox, cur_oy));
		send_box(mk_box(cur_ox - 1, cur_oy, cur_ox, cur_oy));
		send_box(mk_box(cur_ox, cur_oy - 1, cur_ox, cur_oy));
		send_box(mk_box(cur_ox, cur_oy, hx + 1, hy));
		send_box(mk_box(cur_ox, cur_oy, hx, hy + 1));
	endtask

	task automatic run_phase(input int unsigned ox, oy, sz, dep);
		wait_empty();
		// junk in the upper data bits must be dropped by the registers
		write_reg(REG_ORIGIN_X, ($urandom & ~32'hFFFF) | ox);
		write_reg(REG_ORIGIN_Y, ($urandom & ~32'hFFFF) | oy);
		write_reg(REG_SIZE_BITS, ($urandom & ~32'h1F) | sz);
		write_reg(REG_TREE_DEPTH, ($urandom & ~32'h1F) | dep);
		cur_ox = ox;
		cur_oy = oy;
		cur_esz = (sz > COORD_BITS) ? COORD_BITS : sz;
		send_corner_boxes();
		repeat (PHASE_BOXES) send_box(draw_box());
	endtask

	initial begin
		int unsigned hold;
		bit          held_long;
		held_long = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// one long hold-off so the pipeline fills and stalls its input
			if (!held_long && words_taken >= 220) begin
				hold = 150;
				held_long = 1'b1;
				rx_holding = 1'b1;
			end else begin
				hold = rx_quiet ? 0 : $urandom_range(12, 0);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rx_holding = 1'b0;
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			words_taken++;
			if (words_taken % 40 == 0)
				rx_quiet = ($urandom_range(3, 0) == 0);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: origin 0, side 2^16, depth 4
		send_box(mk_box(0, 0, 0, 0));
		send_box(mk_box('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
		send_box(mk_box(0, 0, 'hFFFF, 'hFFFF));
		send_box(mk_box('hFFFF, 'hFFFF, 0, 0));
		send_box(mk_box('h10000, 0, 0, 0));
		send_box(mk_box(0, 'h10000, 0, 0));
		send_box(mk_box(0, 0, 'h10000, 0));
		send_box(mk_box(0, 0, 0, 'h10000));
		send_box(mk_box('h1FFFF, 'h1FFFF, 'h1FFFF, 'h1FFFF));
		send_box(mk_box('h1234, 'h5678, 'h1234, 'h5678));
		send_box(mk_box('h8000, 0, 'h8FFF, 'h0FFF));
		send_box(mk_box('h7FFF, 'h7FFF, 'h8000, 'h8000));
		send_box(mk_box('h0AAA, 'h1555, 'h0AAB, 'h1554));
		send_box(mk_box('h15555, 'h0AAAA, 'h0AAAA, 'h15555));
		send_corner_boxes();
		repeat (40) send_box(draw_box());

		run_phase(0, 0, 16, 16);
		run_phase('hFFFF, 'hFFFF, 0, 0);
		run_phase('h1234, 'hBEEF, 8, 8);
		run_phase($urandom_range('hFFFF, 0), $urandom_range('hFFFF, 0), 31, 31);
		run_phase('h8000, 0, 3, 10);
		run_phase('hFFFF, 0, 16, 1);
		repeat (4)
			run_phase($urandom_range('hFFFF, 0), $urandom_range('hFFFF, 0),
				$urandom_range(31, 0), $urandom_range(31, 0));

		wait_empty();
		if (mismatches == 0 && cells_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/qbcl_pkg.sv
sv/qbcl_cfg_regs.sv
sv/qbcl_pipe.sv
sv/quadtree_box_cell_locator.sv
sv/qbcl_checker.sv
dv/cell_locator_checker.sv
dv/tb.sv
